// ===== src/audio_echo_delay_mixer_top_defines.svh =====
// assertion macros for the echo delay mixer
// expects clk and rst_n in the scope of use
`ifndef AUDIO_ECHO_DELAY_MIXER_TOP_DEFINES_SVH
`define AUDIO_ECHO_DELAY_MIXER_TOP_DEFINES_SVH

// consequence holds in the same cycle
`define AEDM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequence holds in the next cycle
`define AEDM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/aedm_pkg.sv =====
// shared types and constants for the echo delay mixer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package aedm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int DIV_W    = 16;
  localparam int DELAY_W  = 15;
  localparam int CNT_W    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DELAY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIVISOR = 2'd1;

  localparam logic [DELAY_W-1:0] DELAY_RST   = 15'd8000;
  localparam logic [DIV_W-1:0]   DIVISOR_RST = 16'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_DIV,
    S_DONE
  } aedm_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ===== src/aedm_ram.sv =====
// generic single-write, single-read ram with registered read data
// read-first when both ports hit the same address; no dependencies
`timescale 1ns / 1ps
`default_nettype none

module aedm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== src/aedm_div.sv =====
// iterative signed-by-unsigned divider, one quotient bit per cycle
// truncates toward zero; depends on aedm_pkg
`timescale 1ns / 1ps
`default_nettype none

module aedm_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [aedm_pkg::SAMPLE_W-1:0] dividend,
  input  logic        [aedm_pkg::DIV_W-1:0]    divisor,
  output logic signed [aedm_pkg::SAMPLE_W-1:0] quotient,
  output aedm_pkg::div_stat_t                  stat
);
  import aedm_pkg::*;

  logic                busy_r, busy_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                neg_r;
  logic [DIV_W-1:0]    div_r;
  logic [DIV_W-1:0]    rem_r, rem_nxt;
  logic [SAMPLE_W-1:0] quo_r, quo_nxt;
  logic [SAMPLE_W-1:0] mag;
  logic [DIV_W:0]      trial;
  logic [DIV_W:0]      diff;
  logic                ge;

  // most negative input maps to 0x8000, which is its true magnitude
  assign mag   = dividend[SAMPLE_W-1] ? (~dividend + 1'b1) : dividend;
  assign trial = {rem_r, quo_r[SAMPLE_W-1]};
  assign ge    = trial >= {1'b0, div_r};
  assign diff  = trial - {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(SAMPLE_W);
      rem_nxt  = '0;
      quo_nxt  = mag;
    end else if (busy_r) begin
      // dividend bits shift out the top as quotient bits shift in
      rem_nxt = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo_nxt = {quo_r[SAMPLE_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[SAMPLE_W-1];
      div_r <= divisor;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign quotient  = neg_r ? $signed(~quo_r + 1'b1) : $signed(quo_r);
  assign stat.busy = busy_r;
  assign stat.done = busy_r && (cnt_r == CNT_W'(1));

endmodule

`default_nettype wire

// ===== src/audio_echo_delay_mixer_top.sv =====
// echo delay mixer: y = x + trunc(x[n-d] / v), wrapped to 16 bits
// a request passes the start, divide and done states before its result is loaded
// into the output register; the divider takes 16 steps per request, and a new request
// is taken only in idle, while the previous result may still wait in the output register
// reset (synchronous): delay 8000, divisor 4, pointer 0, delay line reads as zero
// until written, tracked by a wrap flag, so no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none
`include "audio_echo_delay_mixer_top_defines.svh"

module audio_echo_delay_mixer_top #(
  parameter int MAX_DELAY = 16384
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_cmd,
  input  logic signed [aedm_pkg::SAMPLE_W-1:0]   in_sample_in,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [aedm_pkg::SAMPLE_W-1:0]   out_sample_out,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic        [aedm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [aedm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import aedm_pkg::*;

  localparam int AW = $clog2(MAX_DELAY);
  localparam int DW = $clog2(MAX_DELAY + 1);
  localparam int PW = DW + 1;

  aedm_state_t state_r, state_nxt;

  logic [AW-1:0]              ptr_r, ptr_nxt;
  logic                       wrapped_r;
  logic signed [SAMPLE_W-1:0] x_r, x_in;
  logic                       past_ok_r;
  logic [DELAY_W-1:0]         delay_r;
  logic [DIV_W-1:0]           divisor_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;

  logic                       in_acc;
  logic                       div_start;
  logic                       out_load;
  logic [DW-1:0]              d_eff;
  logic [DIV_W-1:0]           v_eff;
  logic [PW-1:0]              rd_wrap;
  logic [AW-1:0]              rd_addr;
  logic                       rd_ok;
  logic [SAMPLE_W-1:0]        ram_rdata;
  logic signed [SAMPLE_W-1:0] dividend;
  logic signed [SAMPLE_W-1:0] quotient;
  div_stat_t                  div_st;

  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // delay clamped to 1..MAX_DELAY, divisor zero acts as one
  always_comb begin
    if (delay_r == '0) begin
      d_eff = DW'(1);
    end else if (32'(delay_r) > 32'(MAX_DELAY)) begin
      d_eff = DW'(MAX_DELAY);
    end else begin
      d_eff = DW'(delay_r);
    end
  end

  assign v_eff = (divisor_r == '0) ? DIV_W'(1) : divisor_r;

  // read address behind the write pointer, modulo the line length
  always_comb begin
    if (PW'(ptr_r) >= PW'(d_eff)) begin
      rd_wrap = PW'(ptr_r) - PW'(d_eff);
    end else begin
      rd_wrap = PW'(ptr_r) + PW'(MAX_DELAY) - PW'(d_eff);
    end
  end

  assign rd_addr = rd_wrap[AW-1:0];
  // entries behind the pointer were written since reset, all once it has wrapped
  assign rd_ok   = wrapped_r || (rd_addr < ptr_r);
  assign x_in    = in_cmd ? '0 : in_sample_in;
  assign ptr_nxt = (ptr_r == AW'(MAX_DELAY - 1)) ? '0 : ptr_r + 1'b1;

  aedm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_DELAY),
    .AW    (AW)
  ) u_line (
    .clk   (clk),
    .we    (in_acc),
    .waddr (ptr_r),
    .wdata (x_in),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign dividend = past_ok_r ? $signed(ram_rdata) : '0;

  aedm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (v_eff),
    .quotient (quotient),
    .stat     (div_st)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_st.done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_START: begin
        div_start = 1'b1;
      end
      S_DIV: begin
      end
      S_DONE: begin
        out_load = !out_valid_r || out_ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ptr_r       <= '0;
      wrapped_r   <= 1'b0;
      delay_r     <= DELAY_RST;
      divisor_r   <= DIVISOR_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        ptr_r <= ptr_nxt;
        if (ptr_r == AW'(MAX_DELAY - 1)) begin
          wrapped_r <= 1'b1;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DELAY:   delay_r   <= cfg_data[DELAY_W-1:0];
          CFG_DIVISOR: divisor_r <= cfg_data[DIV_W-1:0];
          default: begin
          end
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r       <= x_in;
      past_ok_r <= rd_ok;
    end
    if (out_load) begin
      out_sample_r <= x_r + quotient;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  `AEDM_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready,
    "request accepted while previous one still in flight")
  `AEDM_ASSERT_SAME(a_done_in_div, div_st.done, state_r == S_DIV,
    "divider finished outside the divide state")
  `AEDM_ASSERT_SAME(a_busy_in_div, div_st.busy, state_r == S_DIV,
    "divider running outside the divide state")
  `AEDM_ASSERT_NEXT(a_ptr_moves, in_valid && in_ready, ptr_r != $past(ptr_r),
    "write pointer did not advance on a request")
  `AEDM_ASSERT_NEXT(a_wrap_sticky, wrapped_r, wrapped_r,
    "wrap flag cleared without reset")

endmodule

`default_nettype wire

// ===== tb/sv/tb_audio_echo_delay_mixer_top.sv =====
// testbench for audio_echo_delay_mixer_top: echo mix of a 16-bit sample stream
// depends on aedm_pkg and the block rtl; holds its own echo predictor and result checker
`timescale 1ns / 1ps

module tb_audio_echo_delay_mixer_top;
  import aedm_pkg::*;

  localparam int LINE_DEPTH  = 16384;
  localparam int LINE_AW     = $clog2(LINE_DEPTH);
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 60;
  localparam int GAP_PCT     = 34;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE3 = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic                         in_cmd = CMD_SAMPLE;
  logic signed [SAMPLE_W-1:0]   in_sample_in = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0]   out_sample_out;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic        [CFG_IDX_W-1:0]  cfg_index = CFG_DELAY;
  logic        [CFG_DATA_W-1:0] cfg_data = '0;

  audio_echo_delay_mixer_top #(
    .MAX_DELAY(LINE_DEPTH)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_sample_in  (in_sample_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sample_out(out_sample_out),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // echo predictor state
  logic [SAMPLE_W-1:0]        echo_hist [LINE_DEPTH];
  int                         line_ptr;
  logic [DELAY_W-1:0]         cur_delay;
  logic [DIV_W-1:0]           cur_div;
  logic signed [SAMPLE_W-1:0] mix_expected [$];

  int   err_count = 0;
  logic gaps_on = 1'b1;
  logic rx_hold = 1'b0;
  event hold_kick;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic echo_model_clear();
    foreach (echo_hist[i]) echo_hist[i] = '0;
    line_ptr  = 0;
    cur_delay = DELAY_RST;
    cur_div   = DIVISOR_RST;
  endtask

  task automatic mix_predict(input logic c, input logic signed [SAMPLE_W-1:0] s);
    int eff_delay;
    int eff_div;
    int x;
    int echo_val;
    int rd;
    logic signed [SAMPLE_W-1:0] y;
    eff_delay = (cur_delay == 0) ? 1 :
                ((int'(cur_delay) > LINE_DEPTH) ? LINE_DEPTH : int'(cur_delay));
    eff_div   = (cur_div == 0) ? 1 : int'(cur_div);
    x         = (c == CMD_FLUSH) ? 0 : int'(s);
    rd        = (line_ptr + LINE_DEPTH - eff_delay) % LINE_DEPTH;
    echo_val  = int'($signed(echo_hist[LINE_AW'(rd)]));
    // int division truncates toward zero, sum wraps on the cast
    y = SAMPLE_W'(x + echo_val / eff_div);
    echo_hist[LINE_AW'(line_ptr)] = SAMPLE_W'(x);
    line_ptr = (line_ptr + 1) % LINE_DEPTH;
    mix_expected.push_back(y);
  endtask

  // result checker and receiver side
  always @(posedge clk) begin
    logic signed [SAMPLE_W-1:0] want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (mix_expected.size() == 0) begin
        report_mismatch($sformatf("sample_out %0d with no request pending", out_sample_out));
      end else begin
        want = mix_expected.pop_front();
        if (out_sample_out !== want)
          report_mismatch($sformatf("sample_out got %0d expected %0d", out_sample_out, want));
      end
    end
    out_ready <= !rx_hold && (!gaps_on || $urandom_range(0, 99) >= GAP_PCT);
  end

  // long receiver hold-off, counted here
  always begin
    @(hold_kick);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  int unsigned watchdog_cycles = 0;
  initial begin
    while (watchdog_cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      watchdog_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_sample(input logic c, input logic signed [SAMPLE_W-1:0] s);
    while (gaps_on && $urandom_range(0, 99) < GAP_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= c;
    in_sample_in <= s;
    do @(posedge clk); while (in_ready !== 1'b1);
    mix_predict(c, s);
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (mix_expected.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      CFG_DELAY:   cur_delay = val[DELAY_W-1:0];
      CFG_DIVISOR: cur_div = val[DIV_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 16'sh7fff;
    if (r < 8) return 16'sh8000;
    if (r < 10) return -16'sd1;
    return SAMPLE_W'($urandom);
  endfunction

  // mostly short delays that hit written history, sometimes the whole history
  function automatic logic [CFG_DATA_W-1:0] pick_delay_word();
    int r;
    int d;
    r = $urandom_range(0, 99);
    if (r < 60)      d = $urandom_range(1, 40);
    else if (r < 85) d = $urandom_range(1, (line_ptr > 1) ? line_ptr : 1);
    else if (r < 92) d = 0;
    else             d = $urandom_range(LINE_DEPTH, 32767);
    return {1'($urandom_range(0, 1)), DELAY_W'(d)};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_divisor_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return CFG_DATA_W'($urandom_range(1, 8));
    if (r < 80) return CFG_DATA_W'($urandom);
    if (r < 90) return '0;
    return ($urandom_range(0, 1) != 0) ? 16'hffff : 16'd1;
  endfunction

  // defaults after reset: long delay reads only unwritten entries, which read as zero
  task automatic test_cleared_line();
    send_sample(CMD_SAMPLE, 16'sh7fff);
    send_sample(CMD_SAMPLE, 16'sh8000);
    send_sample(CMD_FLUSH, 16'sh1234);
    send_sample(CMD_SAMPLE, -16'sd1);
  endtask

  // one-sample echo: wrap on overflow, truncation toward zero, flush writes silence
  task automatic test_wrap_and_divide();
    quiesce();
    write_reg(CFG_DELAY, 16'd1);
    write_reg(CFG_DIVISOR, 16'd1);
    send_sample(CMD_SAMPLE, 16'sh7fff);
    send_sample(CMD_SAMPLE, 16'sh7fff);
    send_sample(CMD_SAMPLE, 16'sh8000);
    send_sample(CMD_SAMPLE, 16'sh8000);
    quiesce();
    write_reg(CFG_DIVISOR, 16'd3);
    send_sample(CMD_SAMPLE, -16'sd7);
    send_sample(CMD_SAMPLE, 16'sd5);
    quiesce();
    // zero delay and zero divisor both act as one; bit 15 of the delay word is dropped
    write_reg(CFG_DELAY, 16'h8000);
    write_reg(CFG_DIVISOR, 16'd0);
    send_sample(CMD_SAMPLE, 16'sd100);
    send_sample(CMD_FLUSH, 16'sd555);
    send_sample(CMD_SAMPLE, 16'sd1);
  endtask

  task automatic test_reg_extremes();
    quiesce();
    write_reg(CFG_DELAY, 16'd2);
    write_reg(CFG_DIVISOR, 16'hffff);
    send_sample(CMD_SAMPLE, 16'sh8000);
    send_sample(CMD_SAMPLE, 16'sd20);
    quiesce();
    // above the line depth saturates to the full depth
    write_reg(CFG_DELAY, 16'h7fff);
    write_reg(CFG_DIVISOR, 16'd2);
    send_sample(CMD_SAMPLE, 16'sd7);
    quiesce();
    write_reg(CFG_DELAY, 16'(LINE_DEPTH));
    send_sample(CMD_SAMPLE, -16'sd9);
    quiesce();
    write_reg(CFG_SPARE2, 16'hffff);
    write_reg(CFG_SPARE3, 16'h0000);
    send_sample(CMD_SAMPLE, 16'sd3);
  endtask

  // receiver stalls long while requests keep coming, so the input backs up
  task automatic test_backpressure();
    quiesce();
    write_reg(CFG_DELAY, 16'd1);
    write_reg(CFG_DIVISOR, 16'd2);
    -> hold_kick;
    repeat (8) send_sample(CMD_SAMPLE, rand_sample());
  endtask

  task automatic test_sender_pause();
    repeat (15) send_sample(CMD_SAMPLE, rand_sample());
    quiesce();
    repeat (15) send_sample(($urandom_range(0, 9) == 0) ? CMD_FLUSH : CMD_SAMPLE,
                           rand_sample());
  endtask

  task automatic test_random_stream();
    for (int phase = 0; phase < 16; phase++) begin
      quiesce();
      gaps_on <= !(phase >= 5 && phase <= 7);
      write_reg(CFG_DELAY, pick_delay_word());
      write_reg(CFG_DIVISOR, pick_divisor_word());
      repeat (100)
        send_sample(($urandom_range(0, 9) == 0) ? CMD_FLUSH : CMD_SAMPLE, rand_sample());
    end
    gaps_on <= 1'b1;
  endtask

  initial begin
    echo_model_clear();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_cleared_line();
    test_wrap_and_divide();
    test_reg_extremes();
    test_backpressure();
    test_sender_pause();
    test_random_stream();
    quiesce();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mix_expected.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", mix_expected.size()));
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
